// File: rtl/xoshiro256pp_generator_with_fork_macros.svh
// assertion helpers shared by the generator rtl
`ifndef XOSHIRO256PP_GENERATOR_WITH_FORK_MACROS_SVH
`define XOSHIRO256PP_GENERATOR_WITH_FORK_MACROS_SVH

// same-cycle implication
`define XOF_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication failed");

// next-cycle implication
`define XOF_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

// File: rtl/xofork_pkg.sv
`timescale 1ns / 1ps
package xofork_pkg;

   localparam int unsigned WordWidth   = 64;
   localparam int unsigned OpWidth     = 3;
   localparam int unsigned BoundWidth  = 31;
   localparam int unsigned MaskWidth   = 52;
   localparam int unsigned IndexWidth  = 3;
   localparam int unsigned CsrIdxWidth = 3;
   localparam int unsigned TryWidth    = 8;

   typedef logic [WordWidth-1:0] word_type;

   localparam logic [OpWidth-1:0] OP_RAW     = 3'd0;
   localparam logic [OpWidth-1:0] OP_FLOAT   = 3'd1;
   localparam logic [OpWidth-1:0] OP_BOUNDED = 3'd2;
   localparam logic [OpWidth-1:0] OP_FORK    = 3'd3;
   localparam logic [OpWidth-1:0] OP_LOAD    = 3'd4;

   localparam logic [CsrIdxWidth-1:0] CSR_SEED_A    = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_SEED_B    = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_SEED_C    = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_SEED_D    = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CSR_SEED_CNT  = 3'd4;

   localparam logic [IndexWidth-1:0] IDX_LAST_CHILD = 3'd3;
   localparam logic [IndexWidth-1:0] IDX_COUNTER    = 3'd4;

   localparam logic [TryWidth-1:0] LAST_TRY = 8'd255;

   localparam word_type COUNTER_MUL = 64'hd1342543de82ef95;

   localparam word_type FORK_XOR [4] = '{
      64'h214c146c88e47cb7, 64'ha66d8cc21285aafa,
      64'h68c7ef2d7b1a54d4, 64'hb053a7d7aa238c61
   };
   localparam word_type FORK_MUL [4] = '{
      64'haef17502108ef2d9, 64'hf34026eeb86766af,
      64'h38fd70ad58dd9fbb, 64'h6677f9b93ab0c04d
   };

   localparam word_type RESET_SEED_A = 64'd1;

endpackage

// File: rtl/xoshiro256pp_generator_with_fork.sv
`timescale 1ns / 1ps
// raw and float draws: one draw step and one scramble add, then the result is registered
// bounded draw: up to 256 tries, each a draw, mix and compare, set by the draw/compare loop
// fork: each child word and the counter are built on one 32x32 multiplier that forms
// each 64-bit product in ST_MUL0 to ST_MUL3; one request at a time, none taken until idle
// reset (synchronous, active high) sets state and seeds to a=1, others zero, no results
module xoshiro256pp_generator_with_fork (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [xofork_pkg::OpWidth-1:0]         req_operation,
   input  logic [xofork_pkg::BoundWidth-1:0]      req_bound,
   input  logic [xofork_pkg::MaskWidth-1:0]       req_draw_mask,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [xofork_pkg::WordWidth-1:0]       rsp_value,
   output logic [xofork_pkg::IndexWidth-1:0]      rsp_word_index,
   output logic                                   rsp_last,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [xofork_pkg::CsrIdxWidth-1:0]     csr_index,
   input  logic [xofork_pkg::WordWidth-1:0]       csr_data
);
   import xofork_pkg::*;
   `include "xoshiro256pp_generator_with_fork_macros.svh"

   typedef enum logic [3:0] {
      ST_IDLE, ST_DRAW, ST_MIX, ST_CHECK, ST_EMIT, ST_FK_SETUP,
      ST_MUL0, ST_MUL1, ST_MUL2, ST_MUL3, ST_FK_ADD, ST_FK_SHIFT,
      ST_FK_FIN, ST_FK_COUNT
   } state_type;

   typedef enum logic [1:0] {PH_CHILD_A, PH_CHILD_B, PH_COUNTER} phase_type;

   state_type state_ff;
   phase_type phase_ff;

   word_type seed_a_ff, seed_b_ff, seed_c_ff, seed_d_ff, seed_cnt_ff;
   word_type gen_a_ff, gen_b_ff, gen_c_ff, gen_d_ff, fork_cnt_ff;

   logic [OpWidth-1:0]    op_ff;
   logic [BoundWidth-1:0] bound_ff;
   logic [MaskWidth-1:0]  mask_ff;
   logic [MaskWidth-1:0]  cand_ff;
   logic [TryWidth-1:0]   tries_ff;
   logic [1:0]            child_ff;

   word_type sum_ff, keep_ff;
   word_type c_ff, mul_a_ff, mul_b_ff, prod_ff, acc_ff;
   word_type out_val_ff;
   logic [IndexWidth-1:0] out_idx_ff;
   logic                  out_last_ff;

   logic                  rsp_valid_ff;
   word_type              rsp_value_ff;
   logic [IndexWidth-1:0] rsp_idx_ff;
   logic                  rsp_last_ff;

   // next generator words after one step
   word_type gen_a_in, gen_b_in, gen_c_in, gen_d_in;
   word_type scr_res, parent_sel, shifted, acc_fin, cnt_in;
   logic [5:0] shift_amt;
   logic [31:0] mul_x, mul_y;

   always_comb begin
      word_type t, c1, d1;
      t = {gen_b_ff[46:0], 17'b0};
      c1 = gen_c_ff ^ gen_a_ff;
      d1 = gen_d_ff ^ gen_b_ff;
      gen_b_in = gen_b_ff ^ c1;
      gen_a_in = gen_a_ff ^ d1;
      gen_c_in = c1 ^ t;
      gen_d_in = {d1[18:0], d1[63:19]};
   end

   assign scr_res = {sum_ff[40:0], sum_ff[63:41]} + keep_ff;

   always_comb begin
      case (child_ff)
         2'd0:    parent_sel = gen_a_ff;
         2'd1:    parent_sel = gen_b_ff;
         2'd2:    parent_sel = gen_c_ff;
         default: parent_sel = gen_d_ff;
      endcase
   end

   assign shift_amt = {1'b0, c_ff[63:59]} + 6'd5;
   assign shifted   = c_ff ^ (c_ff >> shift_amt);
   assign acc_fin   = acc_ff ^ {43'b0, acc_ff[63:43]};
   assign cnt_in    = acc_ff + 64'd1;

   // operand halves for the shared multiplier: lo*lo, lo*hi, hi*lo
   always_comb begin
      case (state_ff)
         ST_MUL0: begin
            mul_x = mul_a_ff[31:0];
            mul_y = mul_b_ff[31:0];
         end
         ST_MUL1: begin
            mul_x = mul_a_ff[31:0];
            mul_y = mul_b_ff[63:32];
         end
         default: begin
            mul_x = mul_a_ff[63:32];
            mul_y = mul_b_ff[31:0];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_CHILD_A;
         rsp_valid_ff <= 1'b0;
         seed_a_ff    <= RESET_SEED_A;
         seed_b_ff    <= '0;
         seed_c_ff    <= '0;
         seed_d_ff    <= '0;
         seed_cnt_ff  <= '0;
         gen_a_ff     <= RESET_SEED_A;
         gen_b_ff     <= '0;
         gen_c_ff     <= '0;
         gen_d_ff     <= '0;
         fork_cnt_ff  <= '0;
         tries_ff     <= '0;
         child_ff     <= '0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_SEED_A:   seed_a_ff   <= csr_data;
               CSR_SEED_B:   seed_b_ff   <= csr_data;
               CSR_SEED_C:   seed_c_ff   <= csr_data;
               CSR_SEED_D:   seed_d_ff   <= csr_data;
               CSR_SEED_CNT: seed_cnt_ff <= csr_data;
               default: ;
            endcase
         end

         if (rsp_valid_ff && rsp_ready && (state_ff != ST_EMIT)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  op_ff    <= req_operation;
                  bound_ff <= req_bound;
                  mask_ff  <= req_draw_mask;
                  tries_ff <= '0;
                  child_ff <= '0;
                  unique case (req_operation) inside
                     OP_RAW, OP_FLOAT, OP_BOUNDED: state_ff <= ST_DRAW;
                     OP_FORK: state_ff <= ST_FK_SETUP;
                     OP_LOAD: begin
                        gen_a_ff    <= seed_a_ff;
                        gen_b_ff    <= seed_b_ff;
                        gen_c_ff    <= seed_c_ff;
                        gen_d_ff    <= seed_d_ff;
                        fork_cnt_ff <= seed_cnt_ff;
                     end
                     default: ;
                  endcase
               end
            end
            ST_DRAW: begin
               sum_ff   <= gen_a_ff + gen_d_ff;
               keep_ff  <= gen_a_ff;
               gen_a_ff <= gen_a_in;
               gen_b_ff <= gen_b_in;
               gen_c_ff <= gen_c_in;
               gen_d_ff <= gen_d_in;
               state_ff <= ST_MIX;
            end
            ST_MIX: begin
               out_idx_ff  <= '0;
               out_last_ff <= 1'b1;
               if (op_ff == OP_RAW) begin
                  out_val_ff <= scr_res;
                  state_ff   <= ST_EMIT;
               end else if (op_ff == OP_FLOAT) begin
                  out_val_ff <= {11'b0, scr_res[63:11]};
                  state_ff   <= ST_EMIT;
               end else begin
                  cand_ff  <= scr_res[63:12] & mask_ff;
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               if (cand_ff <= {21'b0, bound_ff}) begin
                  out_val_ff <= {12'b0, cand_ff};
                  state_ff   <= ST_EMIT;
               end else if (tries_ff == LAST_TRY) begin
                  // out of tries: saturate to the bound
                  out_val_ff <= {33'b0, bound_ff};
                  state_ff   <= ST_EMIT;
               end else begin
                  tries_ff <= tries_ff + 8'd1;
                  state_ff <= ST_DRAW;
               end
            end
            ST_EMIT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_value_ff <= out_val_ff;
                  rsp_idx_ff   <= out_idx_ff;
                  rsp_last_ff  <= out_last_ff;
                  if (out_last_ff) begin
                     state_ff <= ST_IDLE;
                  end else if (out_idx_ff == IDX_LAST_CHILD) begin
                     mul_a_ff <= fork_cnt_ff;
                     mul_b_ff <= COUNTER_MUL;
                     phase_ff <= PH_COUNTER;
                     state_ff <= ST_MUL0;
                  end else begin
                     child_ff <= child_ff + 2'd1;
                     state_ff <= ST_FK_SETUP;
                  end
               end
            end
            ST_FK_SETUP: begin
               c_ff     <= parent_sel;
               mul_a_ff <= fork_cnt_ff ^ FORK_XOR[child_ff];
               mul_b_ff <= {parent_sel[62:0], 1'b1};
               phase_ff <= PH_CHILD_A;
               state_ff <= ST_MUL0;
            end
            ST_MUL0: begin
               prod_ff  <= {32'b0, mul_x} * {32'b0, mul_y};
               state_ff <= ST_MUL1;
            end
            ST_MUL1: begin
               acc_ff   <= prod_ff;
               prod_ff  <= {32'b0, mul_x} * {32'b0, mul_y};
               state_ff <= ST_MUL2;
            end
            ST_MUL2: begin
               acc_ff   <= acc_ff + {prod_ff[31:0], 32'b0};
               prod_ff  <= {32'b0, mul_x} * {32'b0, mul_y};
               state_ff <= ST_MUL3;
            end
            ST_MUL3: begin
               acc_ff <= acc_ff + {prod_ff[31:0], 32'b0};
               unique case (phase_ff)
                  PH_CHILD_A: state_ff <= ST_FK_ADD;
                  PH_CHILD_B: state_ff <= ST_FK_FIN;
                  default:    state_ff <= ST_FK_COUNT;
               endcase
            end
            ST_FK_ADD: begin
               c_ff     <= c_ff + acc_ff;
               state_ff <= ST_FK_SHIFT;
            end
            ST_FK_SHIFT: begin
               mul_a_ff <= shifted;
               mul_b_ff <= FORK_MUL[child_ff];
               phase_ff <= PH_CHILD_B;
               state_ff <= ST_MUL0;
            end
            ST_FK_FIN: begin
               out_val_ff  <= acc_fin;
               out_idx_ff  <= {1'b0, child_ff};
               out_last_ff <= 1'b0;
               state_ff    <= ST_EMIT;
            end
            ST_FK_COUNT: begin
               fork_cnt_ff <= cnt_in;
               out_val_ff  <= cnt_in;
               out_idx_ff  <= IDX_COUNTER;
               out_last_ff <= 1'b1;
               state_ff    <= ST_EMIT;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ready      = (state_ff == ST_IDLE);
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_value      = rsp_value_ff;
   assign rsp_word_index = rsp_idx_ff;
   assign rsp_last       = rsp_last_ff;

   // a fork never moves the generator words
   `XOF_ASSERT_NXT(a_fork_keeps_state, clock, reset,
      (state_ff == ST_FK_SETUP) || (state_ff == ST_FK_FIN),
      $stable(gen_a_ff) && $stable(gen_d_ff))
   // a finished product always hands over to a fork step
   `XOF_ASSERT_NXT(a_mul_return, clock, reset, state_ff == ST_MUL3,
      (state_ff == ST_FK_ADD) || (state_ff == ST_FK_FIN) || (state_ff == ST_FK_COUNT))
   // the last allowed try always ends the request
   `XOF_ASSERT_NXT(a_try_limit, clock, reset,
      (state_ff == ST_CHECK) && (tries_ff == LAST_TRY), state_ff == ST_EMIT)
   // only the counter word carries a non-zero index together with last
   `XOF_ASSERT_IMP(a_last_index, clock, reset, rsp_valid && rsp_last,
      (rsp_word_index == '0) || (rsp_word_index == IDX_COUNTER))

endmodule

// File: tb/sv/xoshiro256pp_generator_with_fork_checker.sv
`timescale 1ns / 1ps
module xoshiro256pp_generator_with_fork_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [xofork_pkg::OpWidth-1:0]      req_operation,
   input  logic [xofork_pkg::BoundWidth-1:0]   req_bound,
   input  logic [xofork_pkg::MaskWidth-1:0]    req_draw_mask,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [xofork_pkg::WordWidth-1:0]    rsp_value,
   input  logic [xofork_pkg::IndexWidth-1:0]   rsp_word_index,
   input  logic                                rsp_last,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [xofork_pkg::CsrIdxWidth-1:0]  csr_index,
   input  logic [xofork_pkg::WordWidth-1:0]    csr_data,
   output int unsigned                         pending_results,
   output int unsigned                         mismatch_count
);
   import xofork_pkg::*;

   localparam int unsigned MaxTries  = 256;

   typedef struct packed {
      word_type                value;
      logic [IndexWidth-1:0]   index;
      logic                    last;
   } gen_word_type;

   word_type     st_a, st_b, st_c, st_d, st_cnt;
   word_type     seed_a, seed_b, seed_c, seed_d, seed_cnt;
   gen_word_type awaited_words [$];
   gen_word_type head;

   function automatic word_type rotl(word_type v, int unsigned k);
      return (v << k) | (v >> (WordWidth - k));
   endfunction

   // one xoshiro256++ output, advancing the generator copy
   function automatic word_type xoshiro_step();
      word_type result;
      word_type t;
      result = rotl(st_a + st_d, 23) + st_a;
      t = st_b << 17;
      st_c = st_c ^ st_a;
      st_d = st_d ^ st_b;
      st_b = st_b ^ st_c;
      st_a = st_a ^ st_d;
      st_c = st_c ^ t;
      st_d = rotl(st_d, 45);
      return result;
   endfunction

   function automatic word_type scramble_child(word_type parent, word_type prev, int unsigned i);
      word_type    c;
      word_type    w;
      int unsigned sh;
      c = parent;
      w = prev ^ FORK_XOR[i];
      c = c + w * ((c << 1) + 64'd1);
      sh = int'(c[63:59]) + 5;
      c = c ^ (c >> sh);
      c = c * FORK_MUL[i];
      c = c ^ (c >> 43);
      return c;
   endfunction

   task automatic await_word(word_type v, logic [IndexWidth-1:0] idx, logic last);
      gen_word_type e;
      e.value = v;
      e.index = idx;
      e.last  = last;
      awaited_words.push_back(e);
   endtask

   task automatic predict_request(logic [OpWidth-1:0] op, logic [BoundWidth-1:0] bound,
                                  logic [MaskWidth-1:0] mask);
      word_type    v;
      word_type    limit;
      word_type    prev;
      word_type    parent [4];
      int unsigned n;
      bit          hit;
      limit = {{(WordWidth-BoundWidth){1'b0}}, bound};
      case (op)
         OP_RAW: await_word(xoshiro_step(), '0, 1'b1);
         OP_FLOAT: await_word(xoshiro_step() >> 11, '0, 1'b1);
         OP_BOUNDED: begin
            v = '0;
            hit = 1'b0;
            for (n = 0; n < MaxTries && !hit; n++) begin
               v = (xoshiro_step() >> 12) & {{(WordWidth-MaskWidth){1'b0}}, mask};
               hit = (v <= limit);
            end
            // out of tries: clamp to the bound
            if (!hit) v = limit;
            await_word(v, '0, 1'b1);
         end
         OP_FORK: begin
            prev = st_cnt;
            parent = '{st_a, st_b, st_c, st_d};
            st_cnt = prev * COUNTER_MUL + 64'd1;
            for (n = 0; n < 4; n++)
               await_word(scramble_child(parent[n], prev, n), IndexWidth'(n), 1'b0);
            await_word(st_cnt, IDX_COUNTER, 1'b1);
         end
         OP_LOAD: begin
            st_a   = seed_a;
            st_b   = seed_b;
            st_c   = seed_c;
            st_d   = seed_d;
            st_cnt = seed_cnt;
         end
         default: ; // spare codes are dropped
      endcase
   endtask

   task automatic flag_mismatch(string msg);
      mismatch_count++;
      $display("mismatch: %s", msg);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         st_a = RESET_SEED_A;
         st_b = '0;
         st_c = '0;
         st_d = '0;
         st_cnt = '0;
         seed_a = RESET_SEED_A;
         seed_b = '0;
         seed_c = '0;
         seed_d = '0;
         seed_cnt = '0;
         awaited_words.delete();
         pending_results = 0;
         mismatch_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_words.size() == 0) begin
               flag_mismatch($sformatf("unexpected word, value %h", rsp_value));
            end else begin
               head = awaited_words.pop_front();
               if (rsp_value !== head.value)
                  flag_mismatch($sformatf("value %h, wanted %h", rsp_value, head.value));
               if (rsp_word_index !== head.index)
                  flag_mismatch($sformatf("word_index %0d, wanted %0d", rsp_word_index,
                                          head.index));
               if (rsp_last !== head.last)
                  flag_mismatch($sformatf("last %b, wanted %b", rsp_last, head.last));
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SEED_A:   seed_a = csr_data;
               CSR_SEED_B:   seed_b = csr_data;
               CSR_SEED_C:   seed_c = csr_data;
               CSR_SEED_D:   seed_d = csr_data;
               CSR_SEED_CNT: seed_cnt = csr_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            predict_request(req_operation, req_bound, req_draw_mask);
         pending_results = awaited_words.size();
      end
   end

endmodule

// File: tb/sv/xoshiro256pp_generator_with_fork_test.sv
`timescale 1ns / 1ps
module xoshiro256pp_generator_with_fork_test;
   import xofork_pkg::*;

   localparam int unsigned CycleLimit   = 2_000_000;
   localparam int unsigned RandomItems  = 420;
   localparam int unsigned Phases       = 4;
   localparam int unsigned SettleCycles = 20;
   localparam int unsigned TailCycles   = 100;

   // codes past the load are spare
   localparam logic [OpWidth-1:0] OpSpareFirst = 3'd5;
   localparam int unsigned        SpareCount   = 3;

   localparam logic [CsrIdxWidth-1:0] SeedRegs [5] = '{
      CSR_SEED_A, CSR_SEED_B, CSR_SEED_C, CSR_SEED_D, CSR_SEED_CNT
   };

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic [OpWidth-1:0]      req_operation;
   logic [BoundWidth-1:0]   req_bound;
   logic [MaskWidth-1:0]    req_draw_mask;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic [WordWidth-1:0]    rsp_value;
   logic [IndexWidth-1:0]   rsp_word_index;
   logic                    rsp_last;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CsrIdxWidth-1:0]  csr_index;
   logic [WordWidth-1:0]    csr_data;

   int unsigned pending_results;
   int unsigned mismatch_count;
   int unsigned cycle_count = 0;
   bit          send_rush = 1'b0;
   bit          take_rush = 1'b0;

   xoshiro256pp_generator_with_fork dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_operation  (req_operation),
      .req_bound      (req_bound),
      .req_draw_mask  (req_draw_mask),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_value      (rsp_value),
      .rsp_word_index (rsp_word_index),
      .rsp_last       (rsp_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   xoshiro256pp_generator_with_fork_checker monitor (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_bound       (req_bound),
      .req_draw_mask   (req_draw_mask),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_value       (rsp_value),
      .rsp_word_index  (rsp_word_index),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .pending_results (pending_results),
      .mismatch_count  (mismatch_count)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("xoshiro256pp_generator_with_fork_test: FAIL");
         $finish;
      end
   end

   function automatic int unsigned pick_gap(bit rush);
      return rush ? 0 : $urandom_range(0, 9);
   endfunction

   function automatic word_type rand_word();
      return {$urandom, $urandom};
   endfunction

   // result side: random hold-offs, lowered only when a gap is drawn
   initial begin
      int unsigned gap;
      int unsigned taken;
      taken = 0;
      rsp_ready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         gap = pick_gap(take_rush);
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         taken++;
         if (taken % 37 == 0) take_rush = ($urandom_range(0, 3) == 0);
         @(negedge clock);
      end
   end

   task automatic send_word(logic [OpWidth-1:0] op, logic [BoundWidth-1:0] bound,
                            logic [MaskWidth-1:0] mask);
      int unsigned gap;
      gap = pick_gap(send_rush);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_operation <= op;
      req_bound     <= bound;
      req_draw_mask <= mask;
      req_valid     <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // hold the sender until every awaited word is back, then a little longer
   task automatic settle(int unsigned tail);
      req_valid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (tail) @(negedge clock);
   endtask

   task automatic load_seeds(word_type a, word_type b, word_type c, word_type d,
                             word_type cnt);
      word_type    vals [5];
      int unsigned i;
      vals = '{a, b, c, d, cnt};
      for (i = 0; i < 5; i++) begin
         csr_index <= SeedRegs[i];
         csr_data  <= vals[i];
         csr_valid <= 1'b1;
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic random_item();
      int unsigned          pick;
      int unsigned          k;
      logic [OpWidth-1:0]   op;
      logic [BoundWidth-1:0] bound;
      logic [MaskWidth-1:0] mask;
      word_type             keep;
      pick  = $urandom_range(0, 99);
      bound = BoundWidth'($urandom);
      mask  = MaskWidth'(rand_word());
      if (pick < 25)      op = OP_RAW;
      else if (pick < 40) op = OP_FLOAT;
      else if (pick < 70) op = OP_BOUNDED;
      else if (pick < 88) op = OP_FORK;
      else if (pick < 92) op = OP_LOAD;
      else                op = OpSpareFirst + OpWidth'($urandom_range(0, SpareCount - 1));
      if (op == OP_BOUNDED) begin
         // mostly narrow masks so draws pass; wide ones run out the tries
         k = ($urandom_range(0, 9) == 0) ? $urandom_range(32, 52) : $urandom_range(1, 31);
         keep = (64'd1 << k) - 64'd1;
         mask = mask & keep[MaskWidth-1:0];
         if (k < BoundWidth) bound = bound & keep[BoundWidth-1:0];
      end
      if ($urandom_range(0, 19) == 0) send_rush = ($urandom_range(0, 2) == 0);
      send_word(op, bound, mask);
   endtask

   initial begin
      int unsigned phase;
      int unsigned done_items;
      int unsigned k;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_operation = OP_RAW;
      req_bound     = '0;
      req_draw_mask = '0;
      csr_valid     = 1'b0;
      csr_index     = CSR_SEED_A;
      csr_data      = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset state, every operation and the edges of the bounded draw
      send_word(OP_RAW, '0, '0);
      send_word(OP_FLOAT, '1, '1);
      send_word(OP_FORK, BoundWidth'($urandom), MaskWidth'(rand_word()));
      send_word(OP_BOUNDED, '1, '1);
      send_word(OP_BOUNDED, '0, '1);
      send_word(OP_BOUNDED, '0, '0);
      send_word(OP_BOUNDED, '1, 52'h7fffffff);
      for (k = 0; k < SpareCount; k++)
         send_word(OpSpareFirst + OpWidth'(k), BoundWidth'($urandom),
                   MaskWidth'(rand_word()));
      send_word(OP_LOAD, '0, '0);
      send_word(OP_RAW, '1, '0);
      send_word(OP_FORK, '0, '1);

      // all-zero generator state
      settle(SettleCycles);
      load_seeds('0, '0, '0, '0, '0);
      send_word(OP_LOAD, '0, '0);
      send_word(OP_RAW, '0, '0);
      send_word(OP_BOUNDED, '0, '1);
      send_word(OP_FORK, '0, '0);
      send_word(OP_FLOAT, '0, '0);

      // all-ones state and counter
      settle(SettleCycles);
      load_seeds('1, '1, '1, '1, '1);
      send_word(OP_LOAD, '1, '1);
      send_word(OP_FORK, '1, '1);
      send_word(OP_RAW, '1, '1);
      send_word(OP_BOUNDED, 31'h3ff, 52'hfff);
      send_word(OP_FORK, '1, '1);

      for (phase = 0; phase < Phases; phase++) begin
         settle(SettleCycles);
         load_seeds(rand_word(), rand_word(), rand_word(), rand_word(), rand_word());
         send_word(OP_LOAD, '0, '0);
         done_items = 0;
         while (done_items < RandomItems / Phases) begin
            random_item();
            done_items++;
         end
      end

      settle(TailCycles);
      if (mismatch_count == 0) begin
         $display("xoshiro256pp_generator_with_fork_test: PASS");
      end else begin
         $display("xoshiro256pp_generator_with_fork_test: FAIL");
      end
      $finish;
   end

endmodule
